@@ rtl/sbmd_pkg.sv @@
// sbmd_pkg: shared constants and the result item type of the sync byte deframer
`default_nettype none

package sbmd_pkg;

   // framing bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] TYPE_FREQ = 8'h46;
   localparam logic [7:0] TYPE_RESP = 8'h52;
   localparam logic [7:0] TYPE_DISC = 8'h44;
   localparam logic [7:0] TYPE_LIST = 8'h4C;

   // frame length counts sync and type bytes
   localparam int unsigned FRAME_LEN   = 6;
   localparam int unsigned PAYLOAD_LEN = FRAME_LEN - 2;

   // result kinds
   localparam logic [2:0] KIND_FREQ       = 3'd0;
   localparam logic [2:0] KIND_RESP       = 3'd1;
   localparam logic [2:0] KIND_DISC       = 3'd2;
   localparam logic [2:0] KIND_LIST_ENTRY = 3'd3;
   localparam logic [2:0] KIND_LIST_EMPTY = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  node_id;
      logic [15:0] illum_tenths;
      logic [7:0]  duty_byte;
      logic [31:0] response_word;
      logic [7:0]  list_index;
      logic        list_last;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/sbmd_if.sv @@
// sbmd_req_if and sbmd_rsp_if: valid/ready channels for received bytes and decoded results
`default_nettype none

interface sbmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  node_id;
   logic [15:0] illum_tenths;
   logic [7:0]  duty_byte;
   logic [31:0] response_word;
   logic [7:0]  list_index;
   logic        list_last;

   modport source (output valid, output kind, output node_id, output illum_tenths,
                   output duty_byte, output response_word, output list_index,
                   output list_last, input ready);
   modport sink   (input valid, input kind, input node_id, input illum_tenths,
                   input duty_byte, input response_word, input list_index,
                   input list_last, output ready);
endinterface

`default_nettype wire

@@ rtl/sbmd_parser.sv @@
// sbmd_parser: frame state machine, one received byte per accepted item
`default_nettype none

module sbmd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [7:0]         rx_byte,
   output logic                    res_valid,
   output sbmd_pkg::result_type    res
);

   // phase codes
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_TYPE = 3'd1;
   localparam logic [2:0] PH_PAY  = 3'd2;
   localparam logic [2:0] PH_CNT  = 3'd3;
   localparam logic [2:0] PH_IDS  = 3'd4;

   localparam logic [7:0] PAY_LAST = 8'(sbmd_pkg::PAYLOAD_LEN - 1);

   logic [2:0]  phase_ff, phase_in;
   logic        is_resp_ff, is_resp_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  list_count_ff, list_count_in;
   logic [7:0]  held_node_ff, held_node_in;
   logic [31:0] payload_ff, payload_in;
   logic [8:0]  index_plus_one;
   logic        list_done;

   assign index_plus_one = {1'b0, byte_index_ff} + 9'd1;
   assign list_done      = (index_plus_one >= {1'b0, list_count_ff});

   // next state and result for the byte on the input
   always_comb begin
      phase_in      = phase_ff;
      is_resp_in    = is_resp_ff;
      byte_index_in = byte_index_ff;
      list_count_in = list_count_ff;
      held_node_in  = held_node_ff;
      payload_in    = payload_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_TYPE: begin
               byte_index_in = '0;
               payload_in    = '0;
               case (rx_byte)
                  sbmd_pkg::TYPE_FREQ: begin
                     is_resp_in = 1'b0;
                     phase_in   = PH_PAY;
                  end
                  sbmd_pkg::TYPE_RESP: begin
                     is_resp_in = 1'b1;
                     phase_in   = PH_PAY;
                  end
                  sbmd_pkg::TYPE_LIST: begin
                     phase_in = PH_CNT;
                  end
                  sbmd_pkg::TYPE_DISC: begin
                     phase_in  = PH_HUNT;
                     res_valid = 1'b1;
                     res.kind  = sbmd_pkg::KIND_DISC;
                  end
                  default: begin
                     phase_in = PH_HUNT;
                  end
               endcase
            end
            PH_PAY: begin
               // F keeps node id and illuminance, R shifts in big-endian
               if (!is_resp_ff) begin
                  if (byte_index_ff == 8'd0) begin
                     held_node_in = rx_byte;
                  end else if (byte_index_ff == 8'd1) begin
                     payload_in = {24'd0, rx_byte};
                  end else if (byte_index_ff == 8'd2) begin
                     payload_in = {16'd0, rx_byte, payload_ff[7:0]};
                  end
               end else begin
                  payload_in = {payload_ff[23:0], rx_byte};
               end
               if (byte_index_ff >= PAY_LAST) begin
                  phase_in      = PH_HUNT;
                  byte_index_in = '0;
                  res_valid     = 1'b1;
                  if (!is_resp_ff) begin
                     res.kind         = sbmd_pkg::KIND_FREQ;
                     res.node_id      = held_node_ff;
                     res.illum_tenths = payload_ff[15:0];
                     res.duty_byte    = rx_byte;
                  end else begin
                     res.kind          = sbmd_pkg::KIND_RESP;
                     res.response_word = payload_in;
                  end
               end else begin
                  byte_index_in = byte_index_ff + 8'd1;
               end
            end
            PH_CNT: begin
               list_count_in = rx_byte;
               byte_index_in = '0;
               if (rx_byte == 8'd0) begin
                  phase_in  = PH_HUNT;
                  res_valid = 1'b1;
                  res.kind  = sbmd_pkg::KIND_LIST_EMPTY;
               end else begin
                  phase_in = PH_IDS;
               end
            end
            PH_IDS: begin
               res_valid      = 1'b1;
               res.kind       = sbmd_pkg::KIND_LIST_ENTRY;
               res.node_id    = rx_byte;
               res.list_index = byte_index_ff;
               res.list_last  = list_done;
               if (list_done) begin
                  phase_in      = PH_HUNT;
                  byte_index_in = '0;
               end else begin
                  byte_index_in = byte_index_ff + 8'd1;
               end
            end
            default: begin
               // hunting, or an unused code
               phase_in = (rx_byte == sbmd_pkg::SYNC_BYTE) ? PH_TYPE : PH_HUNT;
            end
         endcase
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         is_resp_ff    <= 1'b0;
         byte_index_ff <= '0;
         list_count_ff <= '0;
         held_node_ff  <= '0;
         payload_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         is_resp_ff    <= is_resp_in;
         byte_index_ff <= byte_index_in;
         list_count_ff <= list_count_in;
         held_node_ff  <= held_node_in;
         payload_ff    <= payload_in;
      end
   end

   // a final list entry sends the block back to hunting
   a_last_entry_hunts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == sbmd_pkg::KIND_LIST_ENTRY && res.list_last)
      |=> (phase_ff == PH_HUNT))
      else $error("list did not close after last entry");

   // payload counter stays inside the payload
   a_pay_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (byte_index_ff <= PAY_LAST))
      else $error("payload index out of range");

endmodule

`default_nettype wire

@@ rtl/sbmd_out_stage.sv @@
// sbmd_out_stage: result register with a skid entry between parser and result channel
`default_nettype none

module sbmd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire sbmd_pkg::result_type push_data,
   output logic                      can_accept,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output sbmd_pkg::result_type      out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   sbmd_pkg::result_type out_data_ff, out_data_in;
   sbmd_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop        = out_valid_ff && out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   // refill the result register from the skid entry first, then from the parser
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload flops
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while result register is empty");

   // nothing is pushed into a full stage
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed while both entries are full");

endmodule

`default_nettype wire

@@ rtl/sync_byte_message_deframer.sv @@
// sync_byte_message_deframer: top level of the sync byte message deframer
//
//   channel  dir  handshake            payload
//   req_ch   in   valid/ready          rx_byte
//   rsp_ch   out  valid/ready          kind, node_id, illum_tenths, duty_byte,
//                                      response_word, list_index, list_last
//
// one received byte is taken per cycle while req_ch.ready is high; a result is registered
// from the byte that completes it, into a result register backed by one skid entry.
// req_ch.ready is low only while both result entries are full.
// reset is synchronous and returns the parser to hunting for the sync byte.
// a stall on rsp_ch holds the result; bytes keep flowing until the skid entry fills.
`default_nettype none

module sync_byte_message_deframer (
   input  wire logic clock,
   input  wire logic reset,
   sbmd_req_if.sink  req_ch,
   sbmd_rsp_if.source rsp_ch
);

   logic                 fire;
   logic                 can_accept;
   logic                 res_valid;
   sbmd_pkg::result_type res;
   sbmd_pkg::result_type out_data;

   assign req_ch.ready = can_accept;
   assign fire         = req_ch.valid && can_accept;

   // frame decoding
   sbmd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx_byte   (req_ch.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // result buffering
   sbmd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .can_accept (can_accept),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_data   (out_data)
   );

   assign rsp_ch.kind          = out_data.kind;
   assign rsp_ch.node_id       = out_data.node_id;
   assign rsp_ch.illum_tenths  = out_data.illum_tenths;
   assign rsp_ch.duty_byte     = out_data.duty_byte;
   assign rsp_ch.response_word = out_data.response_word;
   assign rsp_ch.list_index    = out_data.list_index;
   assign rsp_ch.list_last     = out_data.list_last;

endmodule

`default_nettype wire
